### rtl/round_robin_slot_allocator_macros.svh
// Assertion macros used by the slot allocator top level.
`ifndef ROUND_ROBIN_SLOT_ALLOCATOR_MACROS_SVH
`define ROUND_ROBIN_SLOT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define RRSA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed");
`define RRSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed");
`else
`define RRSA_ASSERT_IMP(label, ante, cons)
`define RRSA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/rrsa_pkg.sv
// Shared constants and controller/datapath interface types of the slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package rrsa_pkg;

    localparam int POOL_SLOTS_DEF = 64;

    localparam int HANDLE_W  = 7;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int TOTAL_W   = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam int GROUP_W  = 8;
    localparam int GROUP_LG = 3;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_RUNNING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE       = 1'b1;

    localparam logic [CFG_W-1:0] POOL_SIZE_RST = 7'd64;

    typedef struct packed {
        logic load;
        logic advance;
        logic reduce;
        logic scan;
        logic commit;
    } rrsa_cmd_t;

    typedef struct packed {
        logic in_is_put;
        logic full;
        logic slow;
        logic running;
        logic red_last;
        logic out_free;
    } rrsa_stat_t;

endpackage
`default_nettype wire

### rtl/rrsa_datapath.sv
// Datapath of the slot allocator: busy flags, pointer, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module rrsa_datapath #(
    parameter int POOL_SLOTS = rrsa_pkg::POOL_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rrsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rrsa_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           op,
    input  wire logic [rrsa_pkg::HANDLE_W-1:0]  slot_handle,
    input  wire rrsa_pkg::rrsa_cmd_t            cmd,
    output rrsa_pkg::rrsa_stat_t                stat,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rrsa_pkg::STATUS_W-1:0]       status,
    output logic [rrsa_pkg::HANDLE_W-1:0]       granted_handle,
    output logic [rrsa_pkg::COUNT_W-1:0]        slots_in_use,
    output logic [rrsa_pkg::TOTAL_W-1:0]        hit_total,
    output logic [rrsa_pkg::TOTAL_W-1:0]        miss_total
);
    import rrsa_pkg::*;

    localparam int IDX_W  = $clog2(POOL_SLOTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int NG     = (2 * POOL_SLOTS + GROUP_W - 1) / GROUP_W;
    localparam int SCAN_W = NG * GROUP_W;
    localparam int POS_W  = $clog2(SCAN_W);
    localparam int RCNT_W = $clog2(CNT_W);

    logic                running_reg;
    logic [CFG_W-1:0]    pool_reg;
    logic [POOL_SLOTS-1:0] busy_reg, busy_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    sp_reg;
    logic [TOTAL_W-1:0]  hit_reg, hit_next;
    logic [TOTAL_W-1:0]  miss_reg, miss_next;
    logic                fail_reg;
    logic [CNT_W-1:0]    div_reg;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [RCNT_W-1:0]   rcnt_reg;
    logic                op_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [NG-1:0]       grp_any_reg, grp_any_next;
    logic [GROUP_LG-1:0] grp_loc_reg [NG];
    logic [GROUP_LG-1:0] grp_loc_next [NG];
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HANDLE_W-1:0] granted_reg, granted_next;

    logic [CNT_W-1:0]    eff_size;
    logic [CMP_W-1:0]    pool_ext;
    logic [CNT_W-1:0]    v_adv;
    logic [IDX_W-1:0]    fast_sp;
    logic [CNT_W:0]      rem_trial;
    logic [SCAN_W-1:0]   scan_vec;
    logic [POS_W-1:0]    pos, pos_adj;
    logic [IDX_W-1:0]    slot_idx;
    logic [CNT_W-1:0]    grant_val;
    logic                found;
    logic                got;
    logic [CMP_W-1:0]    handle_ext;
    logic [IDX_W-1:0]    handle_idx;
    logic                put_ok;
    logic                fire;
    logic                out_free;

    // Effective pool size: zero acts as one, anything above the pool is clipped.
    always_comb
    begin
        pool_ext = CMP_W'(pool_reg);
        if (pool_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (pool_ext > CMP_W'(POOL_SLOTS))
        begin
            eff_size = CNT_W'(POOL_SLOTS);
        end
        else
        begin
            eff_size = CNT_W'(pool_ext);
        end
    end

    assign v_adv   = CNT_W'(sp_reg) + CNT_W'(1);
    assign fast_sp = (v_adv == eff_size) ? '0 : v_adv[IDX_W-1:0];

    // One restoring remainder step per cycle when the pointer sits beyond a shrunk pool.
    always_comb
    begin
        rem_trial = {rem_reg, div_reg[CNT_W-1]};
        if (rem_trial >= {1'b0, eff_size})
        begin
            rem_trial = rem_trial - {1'b0, eff_size};
        end
        rem_next = rem_trial[CNT_W-1:0];
    end

    // The low half marks free slots at or after the pointer, the high half all free
    // slots, so the lowest set bit of the whole vector is the wrapped next-fit choice.
    always_comb
    begin
        scan_vec = '0;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            scan_vec[POOL_SLOTS + i] = !busy_reg[i] && (CNT_W'(i) < eff_size);
            scan_vec[i] = scan_vec[POOL_SLOTS + i] && (IDX_W'(i) >= sp_reg);
        end
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = |scan_vec[g * GROUP_W +: GROUP_W];
            grp_loc_next[g] = '0;
            for (int j = GROUP_W - 1; j >= 0; j--)
            begin
                if (scan_vec[g * GROUP_W + j])
                begin
                    grp_loc_next[g] = GROUP_LG'(j);
                end
            end
        end
    end

    always_comb
    begin
        pos = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                pos = (POS_W'(g) << GROUP_LG) | POS_W'(grp_loc_reg[g]);
            end
        end
        pos_adj   = (pos >= POS_W'(POOL_SLOTS)) ? (pos - POS_W'(POOL_SLOTS)) : pos;
        slot_idx  = IDX_W'(pos_adj);
        grant_val = CNT_W'(slot_idx) + CNT_W'(1);
    end

    assign found = |grp_any_reg;
    assign got   = !fail_reg && found;

    assign handle_ext = CMP_W'(handle_reg);
    assign handle_idx = IDX_W'(handle_ext - CMP_W'(1));
    assign put_ok     = (handle_reg != '0) && (handle_ext <= CMP_W'(eff_size))
                        && busy_reg[handle_idx];

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = cmd.commit && out_free;

    always_comb
    begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        hit_next     = hit_reg;
        miss_next    = miss_reg;
        status_next  = ST_OK;
        granted_next = '0;
        if (op_reg == OP_PUT)
        begin
            if (put_ok)
            begin
                busy_next[handle_idx] = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            else
            begin
                status_next = ST_INVALID;
            end
        end
        else if (got)
        begin
            busy_next[slot_idx] = 1'b1;
            count_next          = count_reg + CNT_W'(1);
            granted_next        = HANDLE_W'(grant_val);
            if (hit_reg != '1)
            begin
                hit_next = hit_reg + TOTAL_W'(1);
            end
        end
        else
        begin
            status_next = ST_NO_FREE;
            if (miss_reg != '1)
            begin
                miss_next = miss_reg + TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b1;
            pool_reg      <= POOL_SIZE_RST;
            busy_reg      <= '0;
            count_reg     <= '0;
            sp_reg        <= '0;
            hit_reg       <= '0;
            miss_reg      <= '0;
            fail_reg      <= 1'b0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SERVICE_RUNNING: running_reg <= cfg_data[0];
                    REG_POOL_SIZE:       pool_reg    <= cfg_data;
                endcase
            end
            if (cmd.advance)
            begin
                fail_reg <= stat.full || !running_reg;
                rcnt_reg <= '0;
                if (!stat.full && !stat.slow)
                begin
                    sp_reg <= fast_sp;
                end
            end
            if (cmd.reduce)
            begin
                rcnt_reg <= rcnt_reg + RCNT_W'(1);
                if (stat.red_last)
                begin
                    sp_reg <= rem_next[IDX_W-1:0];
                end
            end
            if (fire)
            begin
                busy_reg      <= busy_next;
                count_reg     <= count_next;
                hit_reg       <= hit_next;
                miss_reg      <= miss_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            handle_reg <= slot_handle;
        end
        if (cmd.advance)
        begin
            div_reg <= v_adv;
            rem_reg <= '0;
        end
        if (cmd.reduce)
        begin
            div_reg <= div_reg << 1;
            rem_reg <= rem_next;
        end
        if (cmd.scan)
        begin
            grp_any_reg <= grp_any_next;
            grp_loc_reg <= grp_loc_next;
        end
        if (fire)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    always_comb
    begin
        stat.in_is_put = (op == OP_PUT);
        stat.full      = (count_reg >= eff_size);
        stat.slow      = (v_adv > eff_size);
        stat.running   = running_reg;
        stat.red_last  = (rcnt_reg == RCNT_W'(CNT_W - 1));
        stat.out_free  = out_free;
    end

    // Counters change only when a new result is written, so they drive the outputs directly.
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_handle = granted_reg;
    assign slots_in_use   = COUNT_W'(count_reg);
    assign hit_total      = hit_reg;
    assign miss_total     = miss_reg;

endmodule
`default_nettype wire

### rtl/rrsa_ctrl.sv
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module rrsa_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rrsa_pkg::rrsa_stat_t stat,
    output rrsa_pkg::rrsa_cmd_t       cmd
);
    import rrsa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_ADVANCE = 5'b00010,
        S_REDUCE  = 5'b00100,
        S_SCAN    = 5'b01000,
        S_COMMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = stat.in_is_put ? S_COMMIT : S_ADVANCE;
                end
            end
            S_ADVANCE:
            begin
                cmd.advance = 1'b1;
                if (stat.full)
                begin
                    state_next = S_COMMIT;
                end
                else if (stat.slow)
                begin
                    state_next = S_REDUCE;
                end
                else
                begin
                    state_next = stat.running ? S_SCAN : S_COMMIT;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (stat.red_last)
                begin
                    state_next = stat.running ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // The result register must be free before the request retires.
                cmd.commit = 1'b1;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### rtl/round_robin_slot_allocator.sv
// Top level of the next-fit round-robin slot allocator.
// Path from input transfer to result: a put goes from idle straight to commit. A get
// passes advance, then scan unless the pool is full or the service stopped, then commit;
// remainder steps, one per bit of the advanced pointer, come after advance when the start
// pointer lies beyond a shrunk pool. A new item is taken only from idle, so a stall holds it off.
// Reset clears busy flags, pointer and counters at once and sets running, size 64.
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_slot_allocator_macros.svh"
module round_robin_slot_allocator #(
    parameter int POOL_SLOTS = rrsa_pkg::POOL_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rrsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rrsa_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           op,
    input  wire logic [rrsa_pkg::HANDLE_W-1:0]  slot_handle,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rrsa_pkg::STATUS_W-1:0]       status,
    output logic [rrsa_pkg::HANDLE_W-1:0]       granted_handle,
    output logic [rrsa_pkg::COUNT_W-1:0]        slots_in_use,
    output logic [rrsa_pkg::TOTAL_W-1:0]        hit_total,
    output logic [rrsa_pkg::TOTAL_W-1:0]        miss_total
);
    import rrsa_pkg::*;

    rrsa_cmd_t  cmd;
    rrsa_stat_t stat;

    rrsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrsa_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .op             (op),
        .slot_handle    (slot_handle),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_handle (granted_handle),
        .slots_in_use   (slots_in_use),
        .hit_total      (hit_total),
        .miss_total     (miss_total)
    );

    // A handle is granted only with an ok status.
    `RRSA_ASSERT_IMP(a_grant_only_ok, out_valid && (status != ST_OK), granted_handle == '0)
    // An accepted transfer takes the controller out of idle, which drops in_ready.
    `RRSA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // A rejected put never shows a granted handle.
    `RRSA_ASSERT_IMP(a_invalid_no_grant, out_valid && (status == ST_INVALID), granted_handle == '0)

endmodule
`default_nettype wire
